>>> rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor classifier package
// Shared widths, register map, configuration and stage types, and constant
// tables for the seven-sensor line classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int NUM_SENSORS = 7;
	localparam int THR_BITS    = 12;
	localparam int CNT_BITS    = 3;
	localparam int SUM_BITS    = 4;
	localparam int MAG_BITS    = 3;
	localparam int POS_BITS    = 11;
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_BITS  = RECIP_SHIFT + 1;
	localparam int NUM_BITS    = MAG_BITS + 8;
	localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;
	localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	localparam logic [1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [1:0] REG_JUNCTION_MIN = 2'd1;
	localparam logic [1:0] REG_FINISH_MIN   = 2'd2;

	localparam logic [THR_BITS-1:0] THRESHOLD_RESET    = THR_BITS'(500);
	localparam logic [CNT_BITS-1:0] JUNCTION_MIN_RESET = CNT_BITS'(5);
	localparam logic [CNT_BITS-1:0] FINISH_MIN_RESET   = CNT_BITS'(6);

	localparam logic signed [SUM_BITS-1:0] SENSOR_WEIGHT [NUM_SENSORS] =
		'{-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3};

	typedef logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] sample_vec_t;

	typedef struct packed {
		logic [THR_BITS-1:0] threshold;
		logic [CNT_BITS-1:0] junction_min;
		logic [CNT_BITS-1:0] finish_min;
	} cfg_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]        count;
		logic signed [SUM_BITS-1:0] sum;
		logic                       center;
		logic                       edge_hit;
	} tally_t;

	// Reciprocal of the black count, scaled by two to the sixteenth and rounded up,
	// so that the scaled quotient is exact over the whole range of weight sums.
	function automatic logic [RECIP_BITS-1:0] count_recip(input logic [CNT_BITS-1:0] count);
		logic [RECIP_BITS-1:0] r;
		case (count)
			3'd1: r = RECIP_BITS'(65536);
			3'd2: r = RECIP_BITS'(32768);
			3'd3: r = RECIP_BITS'(21846);
			3'd4: r = RECIP_BITS'(16384);
			3'd5: r = RECIP_BITS'(13108);
			3'd6: r = RECIP_BITS'(10923);
			3'd7: r = RECIP_BITS'(9363);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Line sensor classifier configuration registers
// Bus register file holding the black threshold and the junction and finish
// minimum counts.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [lsc_pkg::ADDR_BITS-1:0]  paddr,
	input  wire logic [lsc_pkg::DATA_BITS-1:0]  pwdata,
	output logic      [lsc_pkg::DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output lsc_pkg::cfg_t                       cfg
);
	import lsc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= THRESHOLD_RESET;
			cfg_q.junction_min <= JUNCTION_MIN_RESET;
			cfg_q.finish_min   <= FINISH_MIN_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_THRESHOLD:    cfg_q.threshold    <= pwdata[THR_BITS-1:0];
				REG_JUNCTION_MIN: cfg_q.junction_min <= pwdata[CNT_BITS-1:0];
				REG_FINISH_MIN:   cfg_q.finish_min   <= pwdata[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD:    prdata = DATA_BITS'(cfg_q.threshold);
			REG_JUNCTION_MIN: prdata = DATA_BITS'(cfg_q.junction_min);
			REG_FINISH_MIN:   prdata = DATA_BITS'(cfg_q.finish_min);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/lsc_threshold.sv
// ----------------------------------------------------------------------------
// Line sensor classifier threshold stage
// First pipeline stage: compares each sample against the black threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_threshold (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire lsc_pkg::sample_vec_t              samples,
	input  wire logic [lsc_pkg::THR_BITS-1:0]      threshold,
	output logic                                   v_s1,
	output logic [lsc_pkg::NUM_SENSORS-1:0]        black_s1
);
	import lsc_pkg::*;

	logic [NUM_SENSORS-1:0] black;

	always_comb begin
		for (int i = 0; i < NUM_SENSORS; i++) begin
			black[i] = CMP_BITS'(samples[i]) < CMP_BITS'(threshold);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		black_s1 <= black;
	end

endmodule

`default_nettype wire

>>> rtl/lsc_tally.sv
// ----------------------------------------------------------------------------
// Line sensor classifier tally stage
// Second pipeline stage: counts black sensors, sums their weights and notes
// whether a centre or an edge sensor sees the line.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_tally (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              v_s1,
	input  wire logic [lsc_pkg::NUM_SENSORS-1:0]   black_s1,
	output logic                                   v_s2,
	output lsc_pkg::tally_t                        tally_s2
);
	import lsc_pkg::*;

	tally_t tally;

	always_comb begin
		tally.count = '0;
		tally.sum   = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			tally.count = tally.count + CNT_BITS'(black_s1[i]);
			tally.sum   = tally.sum + (black_s1[i] ? SENSOR_WEIGHT[i] : SUM_BITS'(0));
		end
		tally.center   = black_s1[2] | black_s1[3] | black_s1[4];
		tally.edge_hit = black_s1[0] | black_s1[1] | black_s1[5] | black_s1[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tally_s2 <= tally;
	end

endmodule

`default_nettype wire

>>> rtl/lsc_result.sv
// ----------------------------------------------------------------------------
// Line sensor classifier result stage
// Third pipeline stage: forms the flags and the mean weight in signed Q.8,
// dividing by the count through a scaled reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_result (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 v_s2,
	input  wire lsc_pkg::tally_t                      tally_s2,
	input  wire lsc_pkg::cfg_t                        cfg,
	output logic                                      done,
	output logic                                      junction_seen,
	output logic                                      finish_seen,
	output logic                                      line_lost,
	output logic [lsc_pkg::CNT_BITS-1:0]              black_count,
	output logic signed [lsc_pkg::POS_BITS-1:0]       position_error
);
	import lsc_pkg::*;

	logic                  neg;
	logic [MAG_BITS-1:0]   mag;
	logic [NUM_BITS-1:0]   num;
	logic [PROD_BITS-1:0]  prod;
	logic [POS_BITS-1:0]   quot;
	logic [POS_BITS-1:0]   pos;

	always_comb begin
		neg  = tally_s2.sum[SUM_BITS-1];
		mag  = neg ? MAG_BITS'(-tally_s2.sum) : MAG_BITS'(tally_s2.sum);
		num  = {mag, 8'b0};
		prod = PROD_BITS'(num) * PROD_BITS'(count_recip(tally_s2.count));
		quot = prod[RECIP_SHIFT +: POS_BITS];
		pos  = neg ? -quot : quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		junction_seen  <= (tally_s2.count >= cfg.junction_min) & tally_s2.center
			& tally_s2.edge_hit;
		finish_seen    <= tally_s2.count >= cfg.finish_min;
		line_lost      <= tally_s2.count == '0;
		black_count    <= tally_s2.count;
		position_error <= pos;
	end

endmodule

`default_nettype wire

>>> rtl/line_sensor_classifier_top.sv
// ----------------------------------------------------------------------------
// Line sensor classifier
// Classifies one vector of seven reflectance samples per word into junction,
// finish and lost flags, a black count and a weighted-centroid position error.
// ----------------------------------------------------------------------------
// Usage:
//   Present sample_0 .. sample_6 with start high; the word is taken at any
//   rising edge where start is high and busy is low. busy never rises, so a
//   new word can be given every cycle.
//   Each word produces one result word through the v_s1, v_s2 and done registers:
//   done is high for exactly one cycle while junction_seen, finish_seen, line_lost,
//   black_count and position_error hold that result. The pipeline has three
//   register stages (threshold compare, count and weight sum, flags and
//   reciprocal multiply), giving one word per cycle sustained throughput.
//   The receiver cannot hold results off, and none is needed.
//   The bus port holds the black threshold (offset 0x0), the junction minimum
//   count (0x4) and the finish minimum count (0x8). Write it only while no
//   word is in flight.
//   Reset clears the pipeline valid bits and loads the registers with a
//   threshold of 500, a junction minimum of 5 and a finish minimum of 6.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_classifier_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [lsc_pkg::ADDR_BITS-1:0]        paddr,
	input  wire logic [lsc_pkg::DATA_BITS-1:0]        pwdata,
	output logic      [lsc_pkg::DATA_BITS-1:0]        prdata,
	output logic                                      pready,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [lsc_pkg::SAMPLE_BITS-1:0]      sample_0,
	input  wire logic [lsc_pkg::SAMPLE_BITS-1:0]      sample_1,
	input  wire logic [lsc_pkg::SAMPLE_BITS-1:0]      sample_2,
	input  wire logic [lsc_pkg::SAMPLE_BITS-1:0]      sample_3,
	input  wire logic [lsc_pkg::SAMPLE_BITS-1:0]      sample_4,
	input  wire logic [lsc_pkg::SAMPLE_BITS-1:0]      sample_5,
	input  wire logic [lsc_pkg::SAMPLE_BITS-1:0]      sample_6,
	output logic                                      done,
	output logic                                      junction_seen,
	output logic                                      finish_seen,
	output logic                                      line_lost,
	output logic [lsc_pkg::CNT_BITS-1:0]              black_count,
	output logic signed [lsc_pkg::POS_BITS-1:0]       position_error
);
	import lsc_pkg::*;

	cfg_t                   cfg;
	sample_vec_t            samples;
	logic                   v_s1;
	logic [NUM_SENSORS-1:0] black_s1;
	logic                   v_s2;
	tally_t                 tally_s2;

	assign busy = 1'b0;

	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;
	assign samples[4] = sample_4;
	assign samples[5] = sample_5;
	assign samples[6] = sample_6;

	lsc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lsc_threshold u_threshold (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start & ~busy),
		.samples   (samples),
		.threshold (cfg.threshold),
		.v_s1      (v_s1),
		.black_s1  (black_s1)
	);

	lsc_tally u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.black_s1 (black_s1),
		.v_s2     (v_s2),
		.tally_s2 (tally_s2)
	);

	lsc_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.v_s2           (v_s2),
		.tally_s2       (tally_s2),
		.cfg            (cfg),
		.done           (done),
		.junction_seen  (junction_seen),
		.finish_seen    (finish_seen),
		.line_lost      (line_lost),
		.black_count    (black_count),
		.position_error (position_error)
	);

endmodule

`default_nettype wire

>>> bench/tb_line_sensor_classifier_top.sv
// ----------------------------------------------------------------------------
// Line sensor classifier testbench
// Drives sample words through the classifier under several threshold and
// minimum-count settings, predicts every reading in a scoreboard and checks
// each strobed result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_line_sensor_classifier_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lsc_pkg::*;

	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic                       junction;
		logic                       finish;
		logic                       lost;
		logic [CNT_BITS-1:0]        count;
		logic signed [POS_BITS-1:0] position;
	} line_reading_t;

	class line_reading_checker;
		logic [THR_BITS-1:0] threshold;
		logic [CNT_BITS-1:0] junction_min;
		logic [CNT_BITS-1:0] finish_min;
		line_reading_t       pending_readings[$];
		int                  failures;

		function new();
			threshold = THRESHOLD_RESET;
			junction_min = JUNCTION_MIN_RESET;
			finish_min = FINISH_MIN_RESET;
			failures = 0;
		endfunction

		function void load_register(logic [1:0] index, logic [DATA_BITS-1:0] value);
			case (index)
				REG_THRESHOLD: begin
					threshold = value[THR_BITS-1:0];
				end
				REG_JUNCTION_MIN: begin
					junction_min = value[CNT_BITS-1:0];
				end
				REG_FINISH_MIN: begin
					finish_min = value[CNT_BITS-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function line_reading_t classify_samples(sample_vec_t word);
			line_reading_t reading;
			int count;
			int weight_sum;
			int magnitude;
			bit centre_hit;
			bit side_hit;
			count = 0;
			weight_sum = 0;
			centre_hit = 1'b0;
			side_hit = 1'b0;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				if (word[i] < threshold) begin
					count++;
					weight_sum += i - 3;
					if (i >= 2 && i <= 4)
						centre_hit = 1'b1;
					else
						side_hit = 1'b1;
				end
			end
			magnitude = 0;
			if (count != 0)
				magnitude = ((weight_sum < 0) ? -weight_sum : weight_sum) * 256 / count;
			reading.junction = (count >= junction_min) && centre_hit && side_hit;
			reading.finish = (count >= finish_min);
			reading.lost = (count == 0);
			reading.count = count[CNT_BITS-1:0];
			reading.position = (weight_sum < 0) ? POS_BITS'(-magnitude) : POS_BITS'(magnitude);
			return reading;
		endfunction

		function void note_sample_word(sample_vec_t word);
			pending_readings.push_back(classify_samples(word));
		endfunction

		function void compare_field(string field, int want, int got);
			if (want != got) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
			end
		endfunction

		function void check_reading(line_reading_t got);
			line_reading_t want;
			if (pending_readings.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: result word with no reading pending", $realtime);
			end else begin
				want = pending_readings.pop_front();
				compare_field("junction_seen", want.junction, got.junction);
				compare_field("finish_seen", want.finish, got.finish);
				compare_field("line_lost", want.lost, got.lost);
				compare_field("black_count", want.count, got.count);
				compare_field("position_error", int'(want.position), int'(got.position));
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_BITS-1:0]    paddr;
	logic [DATA_BITS-1:0]    pwdata;
	logic [DATA_BITS-1:0]    prdata;
	logic                    pready;
	logic                    start;
	logic                    busy;
	logic [SAMPLE_BITS-1:0]  sample_0;
	logic [SAMPLE_BITS-1:0]  sample_1;
	logic [SAMPLE_BITS-1:0]  sample_2;
	logic [SAMPLE_BITS-1:0]  sample_3;
	logic [SAMPLE_BITS-1:0]  sample_4;
	logic [SAMPLE_BITS-1:0]  sample_5;
	logic [SAMPLE_BITS-1:0]  sample_6;
	logic                    done;
	logic                    junction_seen;
	logic                    finish_seen;
	logic                    line_lost;
	logic [CNT_BITS-1:0]     black_count;
	logic signed [POS_BITS-1:0] position_error;

	line_reading_checker readings = new();

	line_sensor_classifier_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.start          (start),
		.busy           (busy),
		.sample_0       (sample_0),
		.sample_1       (sample_1),
		.sample_2       (sample_2),
		.sample_3       (sample_3),
		.sample_4       (sample_4),
		.sample_5       (sample_5),
		.sample_6       (sample_6),
		.done           (done),
		.junction_seen  (junction_seen),
		.finish_seen    (finish_seen),
		.line_lost      (line_lost),
		.black_count    (black_count),
		.position_error (position_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			readings.check_reading(line_reading_t'({junction_seen, finish_seen, line_lost,
				black_count, position_error}));
	end

	function automatic logic [SAMPLE_BITS-1:0] sample_for(bit black, logic [THR_BITS-1:0] thr);
		int pick;
		pick = $urandom_range(0, 3);
		if (black && thr != 0)
			return (pick == 0) ? SAMPLE_BITS'(thr - 1) : SAMPLE_BITS'($urandom_range(0, thr - 1));
		if (!black)
			return (pick == 0) ? SAMPLE_BITS'(thr) : SAMPLE_BITS'($urandom_range(thr, 4095));
		return SAMPLE_BITS'($urandom_range(0, 4095));
	endfunction

	function automatic sample_vec_t masked_word(logic [NUM_SENSORS-1:0] mask);
		sample_vec_t word;
		for (int i = 0; i < NUM_SENSORS; i++)
			word[i] = sample_for(mask[i], readings.threshold);
		return word;
	endfunction

	function automatic sample_vec_t filled_word(logic [SAMPLE_BITS-1:0] value);
		sample_vec_t word;
		for (int i = 0; i < NUM_SENSORS; i++)
			word[i] = value;
		return word;
	endfunction

	function automatic sample_vec_t random_word();
		sample_vec_t word;
		logic [NUM_SENSORS-1:0] mask;
		int density;
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < NUM_SENSORS; i++)
				word[i] = SAMPLE_BITS'($urandom_range(0, 4095));
			return word;
		end
		density = $urandom_range(0, 100);
		for (int i = 0; i < NUM_SENSORS; i++)
			mask[i] = ($urandom_range(0, 99) < density);
		return masked_word(mask);
	endfunction

	task automatic send_word(sample_vec_t word);
		start <= 1'b1;
		sample_0 <= word[0];
		sample_1 <= word[1];
		sample_2 <= word[2];
		sample_3 <= word[3];
		sample_4 <= word[4];
		sample_5 <= word[5];
		sample_6 <= word[6];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		readings.note_sample_word(word);
	endtask

	task automatic sender_pause();
		start <= 1'b0;
		sample_0 <= SAMPLE_BITS'($urandom);
		sample_3 <= SAMPLE_BITS'($urandom);
		@(posedge clk);
	endtask

	task automatic drain_readings();
		start <= 1'b0;
		while (readings.pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic bus_write(logic [1:0] index, logic [DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		readings.load_register(index, value);
	endtask

	task automatic set_limits(logic [THR_BITS-1:0] thr, logic [CNT_BITS-1:0] jmin,
		logic [CNT_BITS-1:0] fmin);
		logic [DATA_BITS-1:0] value;
		value = $urandom;
		value[THR_BITS-1:0] = thr;
		bus_write(REG_THRESHOLD, value);
		value = $urandom;
		value[CNT_BITS-1:0] = jmin;
		bus_write(REG_JUNCTION_MIN, value);
		value = $urandom;
		value[CNT_BITS-1:0] = fmin;
		bus_write(REG_FINISH_MIN, value);
		bus_write(REG_UNMAPPED, $urandom);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_words(int count, int idle_pct, bit hold_midway);
		for (int k = 0; k < count; k++) begin
			while ($urandom_range(0, 99) < idle_pct)
				sender_pause();
			if (hold_midway && k == count / 2)
				drain_readings();
			send_word(random_word());
		end
		drain_readings();
	endtask

	initial begin
		logic [NUM_SENSORS-1:0] directed_masks[$];
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		sample_0 <= '0;
		sample_1 <= '0;
		sample_2 <= '0;
		sample_3 <= '0;
		sample_4 <= '0;
		sample_5 <= '0;
		sample_6 <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(filled_word('0));
		send_word(filled_word('1));
		send_word(filled_word(12'hAAA));
		send_word(filled_word(12'h555));
		send_word(filled_word(SAMPLE_BITS'(readings.threshold - 1)));
		send_word(filled_word(SAMPLE_BITS'(readings.threshold)));
		directed_masks = '{7'b0000001, 7'b0000010, 7'b0000100, 7'b0001000, 7'b0010000,
			7'b0100000, 7'b1000000, 7'b0000011, 7'b0001101, 7'b1110000, 7'b0000110,
			7'b1100011, 7'b0011100, 7'b0011111, 7'b0111111, 7'b1111111};
		foreach (directed_masks[i])
			send_word(masked_word(directed_masks[i]));
		drain_readings();

		set_limits(THRESHOLD_RESET, JUNCTION_MIN_RESET, FINISH_MIN_RESET);
		run_words(140, 15, 1'b0);
		set_limits('0, '0, '0);
		run_words(140, 15, 1'b0);
		set_limits('1, '1, '1);
		run_words(140, 85, 1'b0);
		set_limits(THR_BITS'(2048), '0, '1);
		run_words(140, 85, 1'b1);
		set_limits(THR_BITS'($urandom_range(1, 4094)), CNT_BITS'($urandom),
			CNT_BITS'($urandom));
		run_words(140, 0, 1'b1);
		set_limits(THR_BITS'(1000), CNT_BITS'(3), CNT_BITS'(2));
		run_words(140, 0, 1'b0);

		if (readings.failures == 0 && readings.pending_readings.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
